[hw/rtl/trgbc_pkg.sv]
`default_nettype none
package trgbc_pkg;

	localparam int VERTEX_W         = 11;
	localparam int MAX_VERTICES_DEF = 1024;
	localparam int QUEUE_DEPTH      = 4;

	localparam logic [1:0] DEG_TARGET = 2'd2;
	localparam logic [1:0] DEG_SAT    = 2'd3;

	// One edge word as the back end sees it; the graph summary rides on the last one.
	typedef struct packed {
		logic [VERTEX_W-1:0] end_a;
		logic [VERTEX_W-1:0] end_b;
		logic                store_a;
		logic                store_b;
		logic                last_edge;
		logic                reject;
	} edge_cmd_t;

endpackage
`default_nettype wire

[hw/rtl/trgbc_edge_if.sv]
`default_nettype none
interface trgbc_edge_if;
	logic                          valid;
	logic                          ready;
	logic [trgbc_pkg::VERTEX_W-1:0] end_a;
	logic [trgbc_pkg::VERTEX_W-1:0] end_b;
	logic                          last_edge;

	modport source (output valid, output end_a, output end_b, output last_edge, input ready);
	modport sink (input valid, input end_a, input end_b, input last_edge, output ready);
endinterface
`default_nettype wire

[hw/rtl/trgbc_result_if.sv]
`default_nettype none
interface trgbc_result_if;
	logic valid;
	logic ready;
	logic split_possible;

	modport source (output valid, output split_possible, input ready);
	modport sink (input valid, input split_possible, output ready);
endinterface
`default_nettype wire

[hw/rtl/trgbc_fifo.sv]
`default_nettype none
module trgbc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = trgbc_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full     = (count_q == CNTW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CNTW'(1);
			else if (pop && !push)
				count_q <= count_q - CNTW'(1);
		end
	end
endmodule
`default_nettype wire

[hw/rtl/trgbc_front.sv]
`default_nettype none
module trgbc_front #(
	parameter int MAX_VERTICES = trgbc_pkg::MAX_VERTICES_DEF,
	parameter int CW           = $clog2(MAX_VERTICES + 1),
	parameter int IW           = $bits(trgbc_pkg::edge_cmd_t) + 2 * CW
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	trgbc_edge_if.sink        edges,
	input  wire logic         init_busy,
	input  wire logic         q_full,
	output logic              q_push,
	output logic [IW-1:0]     q_data
);
	localparam int NW = $clog2(MAX_VERTICES + 2);
	localparam int VW = trgbc_pkg::VERTEX_W;

	logic [NW-1:0] cnt_q;
	logic [VW-1:0] big_q;
	logic          zero_q;

	logic [NW-1:0]         cnt_nx;
	logic [VW-1:0]         big_nx;
	logic                  zero_nx;
	logic [31:0]           big_cap;
	logic [31:0]           cnt_cap;
	logic [31:0]           top_w;
	trgbc_pkg::edge_cmd_t  cmd;

	assign edges.ready = !q_full && !init_busy;
	assign q_push      = edges.valid && edges.ready;

	always_comb begin
		cnt_nx  = (32'(cnt_q) <= 32'(MAX_VERTICES)) ? cnt_q + NW'(1) : cnt_q;
		big_nx  = big_q;
		if (edges.end_a > big_nx)
			big_nx = edges.end_a;
		if (edges.end_b > big_nx)
			big_nx = edges.end_b;
		zero_nx = zero_q || (edges.end_a == '0) || (edges.end_b == '0);

		big_cap = (32'(big_nx) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : 32'(big_nx);
		cnt_cap = (32'(cnt_nx) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : 32'(cnt_nx);
		top_w   = (big_cap > cnt_cap) ? big_cap : cnt_cap;

		cmd.end_a     = edges.end_a;
		cmd.end_b     = edges.end_b;
		cmd.store_a   = (edges.end_a != '0) && (edges.end_b != '0)
		                && (32'(edges.end_a) <= 32'(MAX_VERTICES));
		cmd.store_b   = (edges.end_a != '0) && (edges.end_b != '0)
		                && (32'(edges.end_b) <= 32'(MAX_VERTICES));
		cmd.last_edge = edges.last_edge;
		cmd.reject    = zero_nx || (32'(cnt_nx) > 32'(MAX_VERTICES))
		                || (32'(big_nx) > 32'(cnt_nx));
		q_data = {cmd, CW'(cnt_nx), CW'(top_w)};
	end

	// Drop the running summary once the last word of a graph is queued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			big_q  <= '0;
			zero_q <= 1'b0;
		end else if (q_push) begin
			if (edges.last_edge) begin
				cnt_q  <= '0;
				big_q  <= '0;
				zero_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_nx;
				big_q  <= big_nx;
				zero_q <= zero_nx;
			end
		end
	end
endmodule
`default_nettype wire

[hw/rtl/trgbc_back.sv]
`default_nettype none
module trgbc_back #(
	parameter int MAX_VERTICES = trgbc_pkg::MAX_VERTICES_DEF,
	parameter int CW           = $clog2(MAX_VERTICES + 1),
	parameter int IW           = $bits(trgbc_pkg::edge_cmd_t) + 2 * CW
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [IW-1:0] q_data,
	input  wire logic         q_empty,
	output logic              q_pop,
	output logic              init_busy,
	trgbc_result_if.source    result
);
	localparam int VW = trgbc_pkg::VERTEX_W;
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int KW = CW + 1;
	localparam int CMDW = $bits(trgbc_pkg::edge_cmd_t);

	typedef enum logic [13:0] {
		S_INIT    = 14'b00000000000001,
		S_IDLE    = 14'b00000000000010,
		S_A_RD    = 14'b00000000000100,
		S_A_WR    = 14'b00000000001000,
		S_B_RD    = 14'b00000000010000,
		S_B_WR    = 14'b00000000100000,
		S_DC      = 14'b00000001000000,
		S_WK_OUT  = 14'b00000010000000,
		S_WK_CHK  = 14'b00000100000000,
		S_WK_NB   = 14'b00001000000000,
		S_WK_VIS  = 14'b00010000000000,
		S_WK_STEP = 14'b00100000000000,
		S_RESULT  = 14'b01000000000000,
		S_CLEAR   = 14'b10000000000000
	} state_t;

	function automatic logic [AW-1:0] vaddr(input logic [31:0] v);
		logic [31:0] t;
		t = v - 32'd1;
		return t[AW-1:0];
	endfunction

	state_t                state_q;
	trgbc_pkg::edge_cmd_t  cmd_q;
	logic [CW-1:0]         n_q;
	logic [CW-1:0]         top_q;
	logic [KW-1:0]         ctr_q;
	logic [CW-1:0]         x_q;
	logic [VW-1:0]         p_q;
	logic [VW-1:0]         qn_q;
	logic                  par_q;
	logic                  dc_v_s1;
	logic [KW-1:0]         dc_id_s1;
	logic                  out_v_q;
	logic                  out_d_q;

	logic [1:0]    deg_mem [MAX_VERTICES];
	logic [VW-1:0] nb1_mem [MAX_VERTICES];
	logic [VW-1:0] nb2_mem [MAX_VERTICES];
	logic          vis_mem [MAX_VERTICES];

	logic [1:0]    deg_rd_q;
	logic [VW-1:0] nb1_rd_q;
	logic [VW-1:0] nb2_rd_q;
	logic          vis0_rd_q;
	logic          vis1_rd_q;

	trgbc_pkg::edge_cmd_t q_cmd;
	logic [AW-1:0] mem_addr;
	logic [AW-1:0] va0;
	logic [AW-1:0] va1;
	logic          deg_we;
	logic [AW-1:0] deg_wa;
	logic [1:0]    deg_wd;
	logic          nb1_we;
	logic          nb2_we;
	logic [AW-1:0] nb_wa;
	logic [VW-1:0] nb_wd;
	logic          vis_we;
	logic [AW-1:0] vis_wa;
	logic          vis_wd;
	logic          dc_fail;
	logic [KW-1:0] clr_lim;
	logic          out_load;
	logic [1:0]    deg_inc;

	assign q_cmd     = q_data[IW-1 -: CMDW];
	assign init_busy = (state_q == S_INIT);
	assign q_pop     = !q_empty
	                   && ((state_q == S_IDLE) || ((state_q == S_B_WR) && !cmd_q.last_edge));
	assign out_load  = (state_q == S_RESULT) && (!out_v_q || result.ready);
	assign clr_lim   = (state_q == S_INIT) ? KW'(MAX_VERTICES) : KW'(top_q);
	assign deg_inc   = (deg_rd_q == trgbc_pkg::DEG_SAT) ? deg_rd_q : deg_rd_q + 2'd1;
	assign dc_fail   = dc_v_s1 && ((deg_rd_q != trgbc_pkg::DEG_TARGET)
	                   || (32'(nb1_rd_q) == 32'(dc_id_s1))
	                   || (32'(nb2_rd_q) == 32'(dc_id_s1)));

	assign result.valid          = out_v_q;
	assign result.split_possible = out_d_q;

	always_comb begin
		mem_addr = '0;
		va0      = vaddr(32'(ctr_q));
		va1      = '0;
		deg_we   = 1'b0;
		deg_wa   = ctr_q[AW-1:0];
		deg_wd   = '0;
		nb1_we   = 1'b0;
		nb2_we   = 1'b0;
		nb_wa    = vaddr(32'(cmd_q.end_a));
		nb_wd    = cmd_q.end_b;
		vis_we   = 1'b0;
		vis_wa   = ctr_q[AW-1:0];
		vis_wd   = 1'b0;
		unique case (state_q)
			S_INIT, S_CLEAR: begin
				deg_we = 1'b1;
				vis_we = 1'b1;
			end
			S_A_RD: mem_addr = vaddr(32'(cmd_q.end_a));
			S_A_WR: begin
				deg_we = cmd_q.store_a;
				deg_wa = vaddr(32'(cmd_q.end_a));
				deg_wd = deg_inc;
				nb1_we = cmd_q.store_a && (deg_rd_q == 2'd0);
				nb2_we = cmd_q.store_a && (deg_rd_q == 2'd1);
			end
			S_B_RD: mem_addr = vaddr(32'(cmd_q.end_b));
			S_B_WR: begin
				deg_we = cmd_q.store_b;
				deg_wa = vaddr(32'(cmd_q.end_b));
				deg_wd = deg_inc;
				nb1_we = cmd_q.store_b && (deg_rd_q == 2'd0);
				nb2_we = cmd_q.store_b && (deg_rd_q == 2'd1);
				nb_wa  = vaddr(32'(cmd_q.end_b));
				nb_wd  = cmd_q.end_a;
			end
			S_DC:    mem_addr = vaddr(32'(ctr_q));
			S_WK_NB: mem_addr = vaddr(32'(x_q));
			S_WK_VIS: begin
				va0 = vaddr(32'(nb1_rd_q));
				va1 = vaddr(32'(nb2_rd_q));
			end
			S_WK_STEP: begin
				vis_we = !vis0_rd_q || !vis1_rd_q;
				vis_wa = !vis0_rd_q ? vaddr(32'(p_q)) : vaddr(32'(qn_q));
				vis_wd = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (deg_we)
			deg_mem[deg_wa] <= deg_wd;
		if (nb1_we)
			nb1_mem[nb_wa] <= nb_wd;
		if (nb2_we)
			nb2_mem[nb_wa] <= nb_wd;
		if (vis_we)
			vis_mem[vis_wa] <= vis_wd;
		deg_rd_q  <= deg_mem[mem_addr];
		nb1_rd_q  <= nb1_mem[mem_addr];
		nb2_rd_q  <= nb2_mem[mem_addr];
		vis0_rd_q <= vis_mem[va0];
		vis1_rd_q <= vis_mem[va1];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			n_q   <= q_data[2*CW-1 -: CW];
			top_q <= q_data[CW-1:0];
		end
		if (state_q == S_WK_VIS) begin
			p_q  <= nb1_rd_q;
			qn_q <= nb2_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			ctr_q    <= '0;
			x_q      <= '0;
			par_q    <= 1'b0;
			dc_v_s1  <= 1'b0;
			dc_id_s1 <= '0;
			out_v_q  <= 1'b0;
			out_d_q  <= 1'b0;
		end else begin
			if (result.ready && out_v_q && !out_load)
				out_v_q <= 1'b0;
			unique case (state_q)
				S_INIT, S_CLEAR: begin
					ctr_q <= ctr_q + KW'(1);
					if (ctr_q + KW'(1) == clr_lim)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_pop)
						state_q <= S_A_RD;
				end
				S_A_RD: state_q <= S_A_WR;
				S_A_WR: state_q <= S_B_RD;
				S_B_RD: state_q <= S_B_WR;
				S_B_WR: begin
					if (cmd_q.last_edge) begin
						ctr_q   <= KW'(1);
						dc_v_s1 <= 1'b0;
						out_d_q <= out_d_q;
						state_q <= cmd_q.reject ? S_RESULT : S_DC;
						par_q   <= !cmd_q.reject;
					end else if (q_pop) begin
						state_q <= S_A_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DC: begin
					if (dc_fail) begin
						par_q   <= 1'b0;
						state_q <= S_RESULT;
					end else if (ctr_q <= KW'(n_q)) begin
						dc_v_s1  <= 1'b1;
						dc_id_s1 <= ctr_q;
						ctr_q    <= ctr_q + KW'(1);
					end else if (dc_v_s1) begin
						dc_v_s1 <= 1'b0;
					end else begin
						ctr_q   <= KW'(1);
						state_q <= S_WK_OUT;
					end
				end
				S_WK_OUT: begin
					if (ctr_q > KW'(n_q)) begin
						par_q   <= 1'b1;
						state_q <= S_RESULT;
					end else begin
						state_q <= S_WK_CHK;
					end
				end
				S_WK_CHK: begin
					if (vis0_rd_q) begin
						ctr_q   <= ctr_q + KW'(1);
						state_q <= S_WK_OUT;
					end else begin
						x_q     <= CW'(ctr_q);
						par_q   <= 1'b0;
						state_q <= S_WK_NB;
					end
				end
				S_WK_NB:  state_q <= S_WK_VIS;
				S_WK_VIS: state_q <= S_WK_STEP;
				S_WK_STEP: begin
					if (!vis0_rd_q) begin
						x_q     <= CW'(p_q);
						par_q   <= !par_q;
						state_q <= S_WK_NB;
					end else if (!vis1_rd_q) begin
						x_q     <= CW'(qn_q);
						par_q   <= !par_q;
						state_q <= S_WK_NB;
					end else if (par_q) begin
						par_q   <= 1'b0;
						state_q <= S_RESULT;
					end else begin
						ctr_q   <= ctr_q + KW'(1);
						state_q <= S_WK_OUT;
					end
				end
				S_RESULT: begin
					// par_q holds the answer here
					if (out_load) begin
						out_v_q <= 1'b1;
						out_d_q <= par_q;
						ctr_q   <= '0;
						state_q <= (top_q == '0) ? S_IDLE : S_CLEAR;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_pop_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> !q_pop)
		else $error("queue popped during clearing pass");
	a_result_from_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == S_RESULT))
		else $error("result raised outside result state");
	a_edge_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_A_WR) |=> (state_q == S_B_RD))
		else $error("second endpoint not processed after first");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DC) && dc_v_s1) |-> (dc_id_s1 <= KW'(n_q)) && (dc_id_s1 != '0))
		else $error("degree scan vertex out of range");
`endif
endmodule
`default_nettype wire

[hw/rtl/two_regular_graph_bipartite_check_core.sv]
`default_nettype none
// Flow: each edge word leaves the queue and passes S_A_RD, S_A_WR, S_B_RD and S_B_WR, a
//   read-modify-write of the degree store per endpoint; the next word is popped in S_B_WR.
//   The last word adds a degree scan, then the outer walk scan over the vertices and the walk
//   steps (the closing step of each cycle included), then the result register.
// After each result the degree and visited stores are swept over max(N, largest endpoint)
//   entries, capped at MAX_VERTICES. Reset: async, active low; a MAX_VERTICES sweep follows.
module two_regular_graph_bipartite_check_core #(
	parameter int MAX_VERTICES = trgbc_pkg::MAX_VERTICES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	trgbc_edge_if.sink     edges,
	trgbc_result_if.source result
);
	// Width of a vertex count (holds MAX_VERTICES itself)
	localparam int CW = $clog2(MAX_VERTICES + 1);
	// Queue word: edge command plus vertex count and sweep length
	localparam int IW = $bits(trgbc_pkg::edge_cmd_t) + 2 * CW;

	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	logic [IW-1:0] q_wdata;
	logic [IW-1:0] q_rdata;
	logic          init_busy;

	// Front: take edge words, track the graph summary, classify each endpoint.
	trgbc_front #(
		.MAX_VERTICES (MAX_VERTICES),
		.CW           (CW),
		.IW           (IW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.edges     (edges),
		.init_busy (init_busy),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	// Short queue: hold classified words so the front keeps accepting while the back is busy.
	trgbc_fifo #(
		.W     (IW),
		.DEPTH (trgbc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	// Back: store adjacency, scan degrees, walk cycles, emit the answer, sweep the stores.
	trgbc_back #(
		.MAX_VERTICES (MAX_VERTICES),
		.CW           (CW),
		.IW           (IW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (q_rdata),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.result    (result)
	);
endmodule
`default_nettype wire
